[design/smd_pkg.sv]
// Package with the types, constants and round functions shared by the SHA-256 digest block.
package smd_pkg;

    // Payload of one incoming message transaction.
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       has_byte;
        logic       is_last;
    } smd_in_t;

    // Payload of one outgoing digest transaction.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } smd_out_t;

    // Control from the sequencer to the round datapath.
    typedef struct packed {
        logic       shift_byte;
        logic [7:0] shift_data;
        logic       load_work;
        logic       run_round;
        logic [5:0] round_idx;
    } smd_ctrl_t;

    typedef logic [0:7][31:0] smd_hash_t;

    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [63:0] BLOCK_BITS = 64'd512;

    // Standard initial hash values.
    localparam smd_hash_t HASH_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Round constants.
    localparam logic [0:63][31:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Rotate right by a constant amount.
    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

[design/smd_round.sv]
// Round datapath: block shift register, schedule expansion and one compression round per cycle.
module smd_round (
    input  logic              clk,
    input  smd_pkg::smd_ctrl_t ctrl,
    input  smd_pkg::smd_hash_t  chain,
    output smd_pkg::smd_hash_t  work
);
    import smd_pkg::*;

    // The block is held as 16 big-endian words, word 0 in the top bits.
    logic [511:0] sched_reg;
    logic [511:0] sched_next;
    smd_hash_t    work_reg;
    smd_hash_t    work_next;

    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w9;
    logic [31:0] w14;
    logic [31:0] new_word;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    assign w0  = sched_reg[511:480];
    assign w1  = sched_reg[479:448];
    assign w9  = sched_reg[223:192];
    assign w14 = sched_reg[63:32];

    // The first 16 rounds rotate the loaded words; later rounds append expanded words.
    always_comb
    begin
        if (ctrl.round_idx < 6'd16)
        begin
            new_word = w0;
        end
        else
        begin
            new_word = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;
        end
    end

    // Compression round arithmetic.
    always_comb
    begin
        ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
        maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
            ^ (work_reg[1] & work_reg[2]);
        t1  = work_reg[7] + big_sigma1(work_reg[4]) + ch + ROUND_K[ctrl.round_idx] + new_word;
        t2  = big_sigma0(work_reg[0]) + maj;
    end

    // Next values of the block words and the working variables.
    always_comb
    begin
        sched_next = sched_reg;
        work_next  = work_reg;
        if (ctrl.shift_byte)
        begin
            sched_next = {sched_reg[503:0], ctrl.shift_data};
        end
        else if (ctrl.run_round)
        begin
            sched_next = {sched_reg[479:0], new_word};
        end
        if (ctrl.load_work)
        begin
            work_next = chain;
        end
        else if (ctrl.run_round)
        begin
            work_next[7] = work_reg[6];
            work_next[6] = work_reg[5];
            work_next[5] = work_reg[4];
            work_next[4] = work_reg[3] + t1;
            work_next[3] = work_reg[2];
            work_next[2] = work_reg[1];
            work_next[1] = work_reg[0];
            work_next[0] = t1 + t2;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        sched_reg <= sched_next;
        work_reg  <= work_next;
    end

    assign work = work_reg;

endmodule

[design/smd_seq.sv]
// Sequencer: byte intake, padding, round count, chaining value and digest output.
module smd_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                msg_valid,
    output logic                msg_stall,
    input  smd_pkg::smd_in_t    msg_data,
    output logic                digest_valid,
    input  logic                digest_stall,
    output smd_pkg::smd_out_t   digest_data,
    output smd_pkg::smd_ctrl_t  ctrl,
    input  smd_pkg::smd_hash_t  work,
    output smd_pkg::smd_hash_t  chain
);
    import smd_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PREP   = 6'b000010,
        ST_PAD    = 6'b000100,
        ST_ROUND  = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_OUTPUT = 6'b100000
    } smd_state_t;

    smd_state_t  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  word_idx_reg, word_idx_next;
    logic [63:0] bit_len_reg, bit_len_next;
    logic [63:0] len_reg, len_next;
    logic        last_pend_reg, last_pend_next;
    logic        pad_mode_reg, pad_mode_next;
    logic        pad_first_reg, pad_first_next;
    logic        final_blk_reg, final_blk_next;
    smd_hash_t   chain_reg, chain_next;

    logic        len_byte;

    assign msg_stall    = (state_reg != ST_IDLE);
    assign digest_valid = (state_reg == ST_OUTPUT);
    assign len_byte     = final_blk_reg && !pad_first_reg && (fill_reg >= LEN_START);

    // Digest words come straight from the chaining value.
    always_comb
    begin
        digest_data.digest_word = chain_reg[word_idx_reg];
        digest_data.word_index  = word_idx_reg;
        digest_data.last_word   = (word_idx_reg == 3'd7);
    end

    // Main sequencer.
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        round_next     = round_reg;
        word_idx_next  = word_idx_reg;
        bit_len_next   = bit_len_reg;
        len_next       = len_reg;
        last_pend_next = last_pend_reg;
        pad_mode_next  = pad_mode_reg;
        pad_first_next = pad_first_reg;
        final_blk_next = final_blk_reg;
        chain_next     = chain_reg;
        ctrl           = '0;
        ctrl.round_idx = round_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid)
                begin
                    if (msg_data.has_byte)
                    begin
                        ctrl.shift_byte = 1'b1;
                        ctrl.shift_data = msg_data.msg_byte;
                        fill_next       = fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                        begin
                            bit_len_next   = bit_len_reg + BLOCK_BITS;
                            ctrl.load_work = 1'b1;
                            round_next     = 6'd0;
                            last_pend_next = msg_data.is_last;
                            state_next     = ST_ROUND;
                        end
                        else if (msg_data.is_last)
                        begin
                            state_next = ST_PREP;
                        end
                    end
                    else if (msg_data.is_last)
                    begin
                        state_next = ST_PREP;
                    end
                end
            end

            // Capture the message length and set up the padding pass.
            ST_PREP:
            begin
                len_next       = bit_len_reg + {55'd0, fill_reg, 3'd0};
                pad_mode_next  = 1'b1;
                pad_first_next = 1'b1;
                final_blk_next = (fill_reg < LEN_START);
                last_pend_next = 1'b0;
                state_next     = ST_PAD;
            end

            // One padding byte per cycle: marker, zeros, then the length in the final block.
            ST_PAD:
            begin
                ctrl.shift_byte = 1'b1;
                if (pad_first_reg)
                begin
                    ctrl.shift_data = PAD_MARKER;
                end
                else if (len_byte)
                begin
                    ctrl.shift_data = len_reg[63:56];
                    len_next        = {len_reg[55:0], 8'd0};
                end
                else
                begin
                    ctrl.shift_data = 8'd0;
                end
                pad_first_next = 1'b0;
                fill_next      = fill_reg + 6'd1;
                if (fill_reg == 6'd63)
                begin
                    ctrl.load_work = 1'b1;
                    round_next     = 6'd0;
                    state_next     = ST_ROUND;
                end
            end

            ST_ROUND:
            begin
                ctrl.run_round = 1'b1;
                round_next     = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = ST_UPDATE;
                end
            end

            // Fold the working variables into the chaining value and pick what follows.
            ST_UPDATE:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + work[i];
                end
                if (pad_mode_reg)
                begin
                    if (final_blk_reg)
                    begin
                        word_idx_next = 3'd0;
                        state_next    = ST_OUTPUT;
                    end
                    else
                    begin
                        final_blk_next = 1'b1;
                        state_next     = ST_PAD;
                    end
                end
                else if (last_pend_reg)
                begin
                    state_next = ST_PREP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            // Eight digest transactions, then back to the initial state.
            ST_OUTPUT:
            begin
                if (!digest_stall)
                begin
                    word_idx_next = word_idx_reg + 3'd1;
                    if (word_idx_reg == 3'd7)
                    begin
                        chain_next     = HASH_INIT;
                        bit_len_next   = 64'd0;
                        fill_next      = 6'd0;
                        pad_mode_next  = 1'b0;
                        final_blk_next = 1'b0;
                        last_pend_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= 6'd0;
            round_reg     <= 6'd0;
            word_idx_reg  <= 3'd0;
            bit_len_reg   <= 64'd0;
            last_pend_reg <= 1'b0;
            pad_mode_reg  <= 1'b0;
            pad_first_reg <= 1'b0;
            final_blk_reg <= 1'b0;
            chain_reg     <= HASH_INIT;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            round_reg     <= round_next;
            word_idx_reg  <= word_idx_next;
            bit_len_reg   <= bit_len_next;
            last_pend_reg <= last_pend_next;
            pad_mode_reg  <= pad_mode_next;
            pad_first_reg <= pad_first_next;
            final_blk_reg <= final_blk_next;
            chain_reg     <= chain_next;
        end
    end

    // Length shift register is payload.
    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

    assign chain = chain_reg;

endmodule

[design/sha256_message_digest.sv]
// Top level of the SHA-256 digest block: sequencer plus shared round datapath.
// Bytes enter one per transaction while the block is idle; the 64th byte of a block starts
// the 64 compression rounds in the single shared round unit, followed by a fold of the result
// into the chaining value. A transaction with is_last adds a setup step, padding bytes up to
// the end of the block, the compression, and a second padded block when 56 or more bytes
// are pending; then the eight digest words leave one per transaction, word 0 first. The block
// takes no message byte from the end of a message until the eighth digest word has been
// taken, and it then starts the next message from the standard initial hash values.
module sha256_message_digest (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               msg_valid,
    output logic               msg_stall,
    input  smd_pkg::smd_in_t   msg_data,
    output logic               digest_valid,
    input  logic               digest_stall,
    output smd_pkg::smd_out_t  digest_data
);
    import smd_pkg::*;

    smd_ctrl_t ctrl;
    smd_hash_t work;
    smd_hash_t chain;

    // Sequencer and chaining value.
    smd_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg_data     (msg_data),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_data  (digest_data),
        .ctrl         (ctrl),
        .work         (work),
        .chain        (chain)
    );

    // Shared round unit.
    smd_round u_round (
        .clk   (clk),
        .ctrl  (ctrl),
        .chain (chain),
        .work  (work)
    );

endmodule

[bench/tb_sha256_message_digest.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the SHA-256 byte-stream digest block.
module tb_sha256_message_digest;
    import smd_pkg::*;

    // Cycles to keep watching after the last digest word, covering the longest end-of-message work.
    localparam int unsigned QUIET_CYCLES = 400;
    localparam int unsigned ITEMS_PER_PHASE = 6;

    // SHA-256 round constants.
    localparam logic [0:63][31:0] K_TAB = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // SHA-256 initial chaining value.
    localparam logic [0:7][31:0] IV_WORDS = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     msg_valid = 1'b0;
    logic     msg_stall;
    smd_in_t  msg_data = '0;
    logic     digest_valid;
    logic     digest_stall = 1'b0;
    smd_out_t digest_data;

    // Digest model state.
    logic [7:0]  blk_bytes [64];
    int unsigned blk_fill;
    logic [63:0] done_bits;
    logic [31:0] chain [8];

    smd_in_t  pending_items [$];
    smd_out_t digest_expected [$];

    logic        msg_taken = 1'b0;
    int unsigned sender_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned stim_items = 0;
    int unsigned words_checked = 0;
    int unsigned messages_checked = 0;
    int unsigned check_failures = 0;

    sha256_message_digest i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg_data     (msg_data),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_data  (digest_data)
    );

    // Clock generation.
    always #5 clk = ~clk;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        logic [63:0] twice;
        twice = {x, x} >> n;
        return twice[31:0];
    endfunction

    // Start a fresh message from the initial chaining value.
    function automatic void restart_message();
        int i;
        for (i = 0; i < 8; i++)
            chain[i] = IV_WORDS[i];
        blk_fill = 0;
        done_bits = '0;
    endfunction

    // Run the 64 compression rounds over the buffered block and fold into the chain.
    function automatic void fold_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        int i;
        for (i = 0; i < 16; i++)
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        for (i = 16; i < 64; i++)
        begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (i = 0; i < 8; i++)
            v[i] = chain[i];
        for (i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (i = 0; i < 8; i++)
            chain[i] = chain[i] + v[i];
    endfunction

    // Apply one accepted transaction to the model and queue any digest words it produces.
    function automatic void absorb_transaction(input smd_in_t item);
        logic [63:0] total;
        int unsigned idx;
        int i;
        smd_out_t word;
        if (item.has_byte)
        begin
            blk_bytes[blk_fill] = item.msg_byte;
            blk_fill++;
            if (blk_fill == 64)
            begin
                fold_block();
                done_bits = done_bits + 64'd512;
                blk_fill = 0;
            end
        end
        if (item.is_last)
        begin
            // Pad with the marker byte, zeros and the big-endian bit count.
            total = done_bits + 64'(blk_fill) * 64'd8;
            idx = blk_fill;
            blk_bytes[idx] = 8'h80;
            idx++;
            if (idx > 56)
            begin
                while (idx < 64)
                begin
                    blk_bytes[idx] = 8'h00;
                    idx++;
                end
                fold_block();
                idx = 0;
            end
            while (idx < 56)
            begin
                blk_bytes[idx] = 8'h00;
                idx++;
            end
            for (i = 0; i < 8; i++)
                blk_bytes[56 + i] = total[63 - 8*i -: 8];
            fold_block();
            for (i = 0; i < 8; i++)
            begin
                word.digest_word = chain[i];
                word.word_index = 3'(i);
                word.last_word = (i == 7);
                digest_expected.push_back(word);
            end
            restart_message();
        end
    endfunction

    // Input side: sample acceptance, update the model, and check digest words.
    always @(posedge clk)
    begin
        msg_taken <= rst_n && msg_valid && !msg_stall;
        if (rst_n && msg_valid && !msg_stall)
            absorb_transaction(msg_data);
        if (rst_n && digest_valid && !digest_stall)
        begin
            if (digest_expected.size() == 0)
            begin
                $error("digest word %h index %0d arrived with none expected",
                       digest_data.digest_word, digest_data.word_index);
                check_failures++;
            end
            else
            begin
                if (digest_data.digest_word !== digest_expected[0].digest_word)
                begin
                    $error("digest_word: expected %h, got %h",
                           digest_expected[0].digest_word, digest_data.digest_word);
                    check_failures++;
                end
                if (digest_data.word_index !== digest_expected[0].word_index)
                begin
                    $error("word_index: expected %0d, got %0d",
                           digest_expected[0].word_index, digest_data.word_index);
                    check_failures++;
                end
                if (digest_data.last_word !== digest_expected[0].last_word)
                begin
                    $error("last_word: expected %0d, got %0d",
                           digest_expected[0].last_word, digest_data.last_word);
                    check_failures++;
                end
                if (digest_expected[0].last_word)
                    messages_checked++;
                words_checked++;
                void'(digest_expected.pop_front());
            end
        end
    end

    // Driver: present the next transaction once the previous one was taken, with random gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
            msg_valid <= 1'b0;
        else if (!msg_valid || msg_taken)
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                msg_valid <= 1'b1;
                msg_data <= pending_items.pop_front();
            end
            else
                msg_valid <= 1'b0;
        end
        digest_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    task automatic queue_item(input logic [7:0] value, input logic has, input logic last);
        smd_in_t item;
        item.msg_byte = value;
        item.has_byte = has;
        item.is_last = last;
        pending_items.push_back(item);
        stim_items++;
    endtask

    // Queue a message of random bytes, ended on its last byte or by a separate end transaction.
    task automatic queue_message(input int unsigned len, input bit end_on_byte);
        int unsigned k;
        for (k = 0; k < len; k++)
        begin
            if ($urandom_range(99) < 8)
                queue_item(8'($urandom), 1'b0, 1'b0);
            queue_item(8'($urandom), 1'b1, end_on_byte && (k == len - 1));
        end
        if (!end_on_byte || len == 0)
            queue_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // Hold the sender until everything queued has been sent and every digest word has come back.
    task automatic wait_for_drain();
        while (pending_items.size() != 0 || msg_valid || digest_expected.size() != 0)
            @(negedge clk);
    endtask

    // Stimulus sequence.
    initial
    begin
        int unsigned phase;
        int unsigned target;
        int unsigned len;
        restart_message();

        // Directed messages: empty, short, extreme byte values, idle transactions.
        queue_item(8'hff, 1'b0, 1'b0);
        queue_item(8'h00, 1'b0, 1'b1);
        queue_item(8'h61, 1'b1, 1'b0);
        queue_item(8'h62, 1'b1, 1'b0);
        queue_item(8'h63, 1'b1, 1'b1);
        queue_item(8'hff, 1'b1, 1'b1);
        queue_item(8'h00, 1'b1, 1'b0);
        queue_item(8'h5a, 1'b0, 1'b0);
        queue_item(8'hff, 1'b0, 1'b1);
        queue_item(8'h00, 1'b1, 1'b0);
        queue_item(8'hff, 1'b1, 1'b0);
        queue_item(8'h55, 1'b1, 1'b0);
        queue_item(8'haa, 1'b1, 1'b0);
        queue_item(8'h01, 1'b1, 1'b0);
        queue_item(8'h80, 1'b1, 1'b0);
        queue_item(8'hfe, 1'b1, 1'b0);
        queue_item(8'h7f, 1'b1, 1'b1);

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        wait_for_drain();

        // Random messages in four idling phases, draining between phases.
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 60; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 60; end
                default: begin sender_idle_pct = 24; stall_pct = 24; end
            endcase
            // A full block ended on its last byte, and a tail long enough to need an extra
            // padding block.
            if (phase == 1)
                queue_message(64, 1'b1);
            else if (phase == 3)
                queue_message($urandom_range(56, 63), $urandom_range(1));
            target = stim_items + ITEMS_PER_PHASE;
            while (stim_items < target)
            begin
                if ($urandom_range(4) == 0)
                    len = 0;
                else
                    len = $urandom_range(1, 12);
                if (len >= target - stim_items)
                    len = target - stim_items - 1;
                queue_message(len, $urandom_range(1));
            end
            wait_for_drain();
        end

        repeat (QUIET_CYCLES) @(posedge clk);
        $display("Sent %0d input transactions, idle ones included; checked %0d digest words",
                 stim_items, words_checked);
        $display("from %0d messages, covering empty, short and multi-block lengths under stalls.",
                 messages_checked);
        if (check_failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
design/smd_pkg.sv
design/smd_round.sv
design/smd_seq.sv
design/sha256_message_digest.sv
bench/tb_sha256_message_digest.sv
